// File: sv/three_class_block_pool_allocator_assert.svh
// Assertion macros for the three-class block pool allocator.
`ifndef THREE_CLASS_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define THREE_CLASS_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// Clocked check, held off while reset is high.
`define TCBPA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
// Clocked check that also runs through reset.
`define TCBPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define TCBPA_ASSERT(lbl, clk, rst, prop)
`define TCBPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/tcbpa_pkg.sv
// Shared types and constants for the three-class block pool allocator.
package tcbpa_pkg;

  localparam int SMALL_BLOCKS_DEF  = 256;
  localparam int MEDIUM_BLOCKS_DEF = 64;
  localparam int LARGE_BLOCKS_DEF  = 16;

  localparam int SIZE_W  = 16;
  localparam int CLS_W   = 2;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 16;

  localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_LIMIT  = 2'd2;

  localparam logic [SIZE_W-1:0] SMALL_LIMIT_RST  = 16'd64;
  localparam logic [SIZE_W-1:0] MEDIUM_LIMIT_RST = 16'd256;
  localparam logic [SIZE_W-1:0] LARGE_LIMIT_RST  = 16'd1024;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic init_step;
    logic accept;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic pop_hit;
  } dp_stat_t;

endpackage

// File: sv/tcbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tcbpa_ctrl.sv
// Controller state machine: link-store init pass, request accept, pop completion.
module tcbpa_ctrl import tcbpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (stat.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && stat.pop_hit) state_next = ST_POP;
      end
      ST_POP: state_next = ST_IDLE;
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd.init_step = (state == ST_INIT);
    cmd.accept    = (state == ST_IDLE) && start;
    cmd.finish    = (state == ST_POP);
    busy          = (state != ST_IDLE);
  end

endmodule

// File: sv/tcbpa_dp.sv
// Datapath: limits, list heads, next-pointer RAMs, counters and result registers.
module tcbpa_dp import tcbpa_pkg::*; #(
  parameter int SMALL_N  = SMALL_BLOCKS_DEF,
  parameter int MEDIUM_N = MEDIUM_BLOCKS_DEF,
  parameter int LARGE_N  = LARGE_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 mode,
  input  logic [SIZE_W-1:0]    request_size,
  input  logic [CLS_W-1:0]     free_class,
  input  logic [IDX_W-1:0]     free_index,
  output logic                 done,
  output logic                 ok,
  output logic [CLS_W-1:0]     pool_class,
  output logic [IDX_W-1:0]     block_index,
  output logic [CNT_W-1:0]     alloc_count,
  output logic [CNT_W-1:0]     free_count
);

  localparam int S_AW = (SMALL_N > 1) ? $clog2(SMALL_N) : 1;
  localparam int M_AW = (MEDIUM_N > 1) ? $clog2(MEDIUM_N) : 1;
  localparam int L_AW = (LARGE_N > 1) ? $clog2(LARGE_N) : 1;
  localparam int S_PW = $clog2(SMALL_N + 1);
  localparam int M_PW = $clog2(MEDIUM_N + 1);
  localparam int L_PW = $clog2(LARGE_N + 1);
  localparam int MAX_N = (SMALL_N > MEDIUM_N) ?
                         ((SMALL_N > LARGE_N) ? SMALL_N : LARGE_N) :
                         ((MEDIUM_N > LARGE_N) ? MEDIUM_N : LARGE_N);
  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  logic [SIZE_W-1:0] small_limit, medium_limit, large_limit;
  logic [S_PW-1:0]   small_head;
  logic [M_PW-1:0]   medium_head;
  logic [L_PW-1:0]   large_head;
  logic [CNT_W-1:0]  alloc_counter, free_counter;
  logic [IW-1:0]     init_cnt;
  logic [CLS_W-1:0]  pop_cls;

  logic [S_PW-1:0]   s_link;
  logic [M_PW-1:0]   m_link;
  logic [L_PW-1:0]   l_link;
  logic              s_we, m_we, l_we;
  logic              s_avail, m_avail, l_avail;
  logic [CLS_W-1:0]  alloc_cls;
  logic              avail_sel;
  logic              free_ok;
  logic              is_free;

  always_comb begin
    s_avail = 32'(small_head) < 32'(SMALL_N);
    m_avail = 32'(medium_head) < 32'(MEDIUM_N);
    l_avail = 32'(large_head) < 32'(LARGE_N);

    priority if (request_size <= small_limit)  alloc_cls = CLS_SMALL;
    else if (request_size <= medium_limit)     alloc_cls = CLS_MEDIUM;
    else if (request_size <= large_limit)      alloc_cls = CLS_LARGE;
    else                                       alloc_cls = CLS_NONE;

    unique case (alloc_cls)
      CLS_SMALL:  avail_sel = s_avail;
      CLS_MEDIUM: avail_sel = m_avail;
      CLS_LARGE:  avail_sel = l_avail;
      default:    avail_sel = 1'b0;
    endcase

    unique case (free_class)
      CLS_SMALL:  free_ok = 32'(free_index) < 32'(SMALL_N);
      CLS_MEDIUM: free_ok = 32'(free_index) < 32'(MEDIUM_N);
      CLS_LARGE:  free_ok = 32'(free_index) < 32'(LARGE_N);
      default:    free_ok = 1'b0;
    endcase

    stat.pop_hit   = (mode == MODE_ALLOC) && avail_sel;
    stat.init_last = 32'(init_cnt) == 32'(MAX_N - 1);
    is_free        = cmd.accept && (mode == MODE_FREE) && free_ok;

    s_we = (cmd.init_step && 32'(init_cnt) < 32'(SMALL_N)) ||
           (is_free && free_class == CLS_SMALL);
    m_we = (cmd.init_step && 32'(init_cnt) < 32'(MEDIUM_N)) ||
           (is_free && free_class == CLS_MEDIUM);
    l_we = (cmd.init_step && 32'(init_cnt) < 32'(LARGE_N)) ||
           (is_free && free_class == CLS_LARGE);
  end

  tcbpa_ram #(.WIDTH(S_PW), .DEPTH(SMALL_N)) u_small_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (cmd.init_step ? S_AW'(init_cnt) : S_AW'(free_index)),
    .wdata (cmd.init_step ? S_PW'(32'(init_cnt) + 32'd1) : small_head),
    .raddr (S_AW'(small_head)),
    .rdata (s_link)
  );

  tcbpa_ram #(.WIDTH(M_PW), .DEPTH(MEDIUM_N)) u_medium_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (cmd.init_step ? M_AW'(init_cnt) : M_AW'(free_index)),
    .wdata (cmd.init_step ? M_PW'(32'(init_cnt) + 32'd1) : medium_head),
    .raddr (M_AW'(medium_head)),
    .rdata (m_link)
  );

  tcbpa_ram #(.WIDTH(L_PW), .DEPTH(LARGE_N)) u_large_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (cmd.init_step ? L_AW'(init_cnt) : L_AW'(free_index)),
    .wdata (cmd.init_step ? L_PW'(32'(init_cnt) + 32'd1) : large_head),
    .raddr (L_AW'(large_head)),
    .rdata (l_link)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      small_limit   <= SMALL_LIMIT_RST;
      medium_limit  <= MEDIUM_LIMIT_RST;
      large_limit   <= LARGE_LIMIT_RST;
      small_head    <= '0;
      medium_head   <= '0;
      large_head    <= '0;
      alloc_counter <= '0;
      free_counter  <= '0;
      init_cnt      <= '0;
      done          <= 1'b0;
    end else begin
      if (cmd.init_step) init_cnt <= init_cnt + IW'(1);

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SMALL_LIMIT:  small_limit  <= cfg_data;
          CFG_MEDIUM_LIMIT: medium_limit <= cfg_data;
          CFG_LARGE_LIMIT:  large_limit  <= cfg_data;
          default: ;
        endcase
      end

      done <= (cmd.accept && !stat.pop_hit) || cmd.finish;

      // push: new head is the freed block, its link the old head
      if (is_free) begin
        free_counter <= free_counter + CNT_W'(1);
        unique case (free_class)
          CLS_SMALL:  small_head  <= S_PW'(free_index);
          CLS_MEDIUM: medium_head <= M_PW'(free_index);
          CLS_LARGE:  large_head  <= L_PW'(free_index);
          default: ;
        endcase
      end

      if (cmd.finish) begin
        alloc_counter <= alloc_counter + CNT_W'(1);
        unique case (pop_cls)
          CLS_SMALL:  small_head  <= s_link;
          CLS_MEDIUM: medium_head <= m_link;
          CLS_LARGE:  large_head  <= l_link;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.pop_hit) begin
      pop_cls <= alloc_cls;
    end
    if (cmd.accept && !stat.pop_hit) begin
      ok          <= (mode == MODE_FREE) && free_ok;
      pool_class  <= CLS_NONE;
      block_index <= '0;
    end
    if (cmd.finish) begin
      ok         <= 1'b1;
      pool_class <= pop_cls;
      unique case (pop_cls)
        CLS_SMALL:  block_index <= IDX_W'(small_head);
        CLS_MEDIUM: block_index <= IDX_W'(medium_head);
        CLS_LARGE:  block_index <= IDX_W'(large_head);
        default:    block_index <= '0;
      endcase
    end
  end

  assign alloc_count = alloc_counter;
  assign free_count  = free_counter;

endmodule

// File: sv/three_class_block_pool_allocator.sv
// Top level of the three-class block pool allocator.
// After reset the block runs an init pass that links every free list in
// ascending order; it steps through as many blocks as the largest pool has
// (256 at default sizes), with busy high. A request is taken when start is
// high and busy is low. A free, or an allocate that fails, gives its result
// in the cycle after it is taken. A successful allocate goes through ST_POP,
// since the head's next pointer is read from the pool's RAM before the head
// can advance; busy is high in ST_POP. Each result shows for exactly one cycle
// with done high and is not held, so the receiver must take it then.
// Limit writes are taken at any time and should be made only while idle.
`include "three_class_block_pool_allocator_assert.svh"

module three_class_block_pool_allocator import tcbpa_pkg::*; #(
  parameter int SMALL_BLOCKS  = SMALL_BLOCKS_DEF,
  parameter int MEDIUM_BLOCKS = MEDIUM_BLOCKS_DEF,
  parameter int LARGE_BLOCKS  = LARGE_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode,
  input  logic [SIZE_W-1:0]    request_size,
  input  logic [CLS_W-1:0]     free_class,
  input  logic [IDX_W-1:0]     free_index,
  output logic                 done,
  output logic                 ok,
  output logic [CLS_W-1:0]     pool_class,
  output logic [IDX_W-1:0]     block_index,
  output logic [CNT_W-1:0]     alloc_count,
  output logic [CNT_W-1:0]     free_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcbpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tcbpa_dp #(
    .SMALL_N  (SMALL_BLOCKS),
    .MEDIUM_N (MEDIUM_BLOCKS),
    .LARGE_N  (LARGE_BLOCKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .request_size (request_size),
    .free_class   (free_class),
    .free_index   (free_index),
    .done         (done),
    .ok           (ok),
    .pool_class   (pool_class),
    .block_index  (block_index),
    .alloc_count  (alloc_count),
    .free_count   (free_count)
  );

  `TCBPA_ASSERT_ALWAYS(a_busy_after_rst, clk, rst |=> busy)
  `TCBPA_ASSERT(a_accept_answers, clk, rst, start && !busy |=> done || busy)
  `TCBPA_ASSERT(a_fail_clean, clk, rst,
    done && !ok |-> pool_class == CLS_NONE && block_index == '0)
  `TCBPA_ASSERT(a_pop_one_cycle, clk, rst, cmd.finish |=> !cmd.finish && done)

endmodule
